@@ rtl/lts_pkg.sv @@
// ----------------------------------------------------------------------------
// lts_pkg: shared types, constants and table builders
// Item types, internal word formats, colour matrix and the elaboration-time
// procedures that fill the trigonometric and gamma power tables.
// ----------------------------------------------------------------------------
package lts_pkg;

	localparam int TRIG_ENTRIES  = 1024;
	localparam int TRIG_IDX_W    = $clog2(TRIG_ENTRIES);
	localparam int GAMMA_ENTRIES = 1024;
	localparam int GAM_IDX_W     = $clog2(GAMMA_ENTRIES);
	localparam int POW_IDX_W     = $clog2(GAMMA_ENTRIES + 1);
	localparam int LATENCY       = 16;

	localparam int FY_W   = 21;
	localparam int F_W    = 22;
	localparam int LAB_W  = 24;
	localparam int MAT_W  = 27;
	localparam int PROD_W = 51;
	localparam int ACC_W  = 53;
	localparam int LIN_W  = 30;
	localparam int TRIG_W = 18;
	localparam int POW_W  = 25;

	typedef struct packed {
		logic [12:0] hue;
		logic [14:0] chroma;
		logic [14:0] lightness;
	} lch_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
	} rgb_t;

	typedef logic signed [F_W-1:0]    f_t;
	typedef logic signed [LAB_W-1:0]  lab_t;
	typedef logic signed [LIN_W-1:0]  lin_t;
	typedef logic signed [TRIG_W-1:0] trig_t;
	typedef trig_t trig_tab_t [TRIG_ENTRIES];
	typedef logic [POW_W-1:0] pow_tab_t [GAMMA_ENTRIES + 1];

	localparam logic signed [MAT_W-1:0] MAT [3][3] = '{
		'{ 27'sd50700304, -27'sd27135343, -27'sd6792685 },
		'{-27'sd15833771,  27'sd32149837,  27'sd463171  },
		'{ 27'sd1164464,  -27'sd3841745,   27'sd19457173}
	};

	localparam logic [63:0] Q28_HALF_PI = 64'd421657428;

	typedef struct packed {
		logic [63:0]        m;
		logic signed [31:0] e;
	} pf_t;

	function automatic pf_t pf_from(input logic [63:0] v);
		pf_t r;
		logic [63:0] x;
		r.m = '0;
		r.e = '0;
		x = v;
		if (x != 64'd0) begin
			while (x >= 64'h1_0000_0000) begin
				x = x >> 1;
				r.e = r.e + 32'sd1;
			end
			while (x < 64'h8000_0000) begin
				x = x << 1;
				r.e = r.e - 32'sd1;
			end
			r.m = x;
		end
		return r;
	endfunction

	function automatic pf_t pf_mul(input pf_t a, input pf_t b);
		pf_t r;
		logic [63:0] p;
		r.m = '0;
		r.e = '0;
		if (a.m != 64'd0 && b.m != 64'd0) begin
			p = (a.m * b.m) >> 31;
			r.e = a.e + b.e + 32'sd31;
			if (p >= 64'h1_0000_0000) begin
				p = p >> 1;
				r.e = r.e + 32'sd1;
			end
			r.m = p;
		end
		return r;
	endfunction

	function automatic pf_t pf_pow(input pf_t a, input int n);
		pf_t r;
		r = a;
		for (int i = 1; i < n; i++) r = pf_mul(r, a);
		return r;
	endfunction

	function automatic logic pf_le(input pf_t a, input pf_t b);
		logic res;
		if (a.m == 64'd0) res = 1'b1;
		else if (b.m == 64'd0) res = 1'b0;
		else if (a.e != b.e) res = (a.e < b.e);
		else res = (a.m <= b.m);
		return res;
	endfunction

	// truncating quotient by restoring long division
	function automatic logic [63:0] long_div(input logic [63:0] num, input logic [63:0] den);
		logic [63:0] q;
		logic [64:0] rem;
		q = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[63:0], num[i]};
			if (rem >= {1'b0, den}) begin
				rem = rem - {1'b0, den};
				q[i] = 1'b1;
			end
		end
		return q;
	endfunction

	// sine or cosine of a Q28 angle in the first quadrant, Q16 result
	function automatic trig_t series_q16(input logic [63:0] x, input logic want_sin);
		logic [63:0] x2;
		logic [63:0] term;
		logic [63:0] d;
		longint acc;
		x2 = (x * x) >> 28;
		term = want_sin ? x : 64'h1000_0000;
		acc = longint'(term);
		for (int n = 1; n <= 9; n++) begin
			d = want_sin ? 64'((2 * n) * (2 * n + 1)) : 64'((2 * n - 1) * (2 * n));
			term = long_div((term * x2) >> 28, d);
			if (n[0]) acc = acc - longint'(term);
			else acc = acc + longint'(term);
		end
		if (acc < 0) acc = 0;
		if (acc > 64'sh1000_0000) acc = 64'sh1000_0000;
		return TRIG_W'((acc + 2048) >>> 12);
	endfunction

	function automatic trig_tab_t make_trig(input logic want_sin);
		trig_tab_t t;
		logic [63:0] p;
		logic [63:0] x;
		trig_t s;
		trig_t c;
		for (int k = 0; k < TRIG_ENTRIES; k++) begin
			p = (64'(k) << 32) >> TRIG_IDX_W;
			x = ((p & 64'h3FFF_FFFF) * Q28_HALF_PI) >> 30;
			s = series_q16(x, 1'b1);
			c = series_q16(x, 1'b0);
			case (p[31:30])
				2'd0:    t[k] = want_sin ? s : c;
				2'd1:    t[k] = want_sin ? c : -s;
				2'd2:    t[k] = want_sin ? -s : -c;
				default: t[k] = want_sin ? -c : s;
			endcase
		end
		return t;
	endfunction

	// entry k holds (k/N)^(5/12) in Q24, truncated
	function automatic pow_tab_t make_pow();
		pow_tab_t t;
		pf_t npow;
		pf_t rhs;
		logic [63:0] lo;
		logic [63:0] hi;
		logic [63:0] mid;
		npow = pf_pow(pf_from(64'(GAMMA_ENTRIES)), 5);
		for (int k = 0; k <= GAMMA_ENTRIES; k++) begin
			lo = 64'd0;
			hi = 64'd1 << 24;
			rhs = pf_pow(pf_from(64'(k)), 5);
			rhs.e = rhs.e + 32'sd288;
			while (lo < hi) begin
				mid = (lo + hi + 64'd1) >> 1;
				if (pf_le(pf_mul(pf_pow(pf_from(mid), 12), npow), rhs)) lo = mid;
				else hi = mid - 64'd1;
			end
			t[k] = POW_W'(lo);
		end
		return t;
	endfunction

endpackage

@@ rtl/lch_to_srgb_convert_top.sv @@
// ----------------------------------------------------------------------------
// lch_to_srgb_convert_top: CIE LCh to 8-bit sRGB
// Fixed-point colour conversion pipeline, one pixel per clock.
// ----------------------------------------------------------------------------
// Usage:
//   Drive lch with hue (sixteenths of a degree), chroma and lightness
//   (both Q7.8) and raise start; the item is taken on any edge with start
//   high, as busy is held low and the pipeline takes one item every clock.
//   Once the item has passed every stage, done is high for one cycle with the rgb triple.
//   Items leave in the order they entered.
//   The stages are seven for hue lookup and offsets, two for the Lab cube,
//   three for the matrix and four for the interpolated gamma table.
//   Throughput is one item per cycle.
//   Tables are constant ROMs; no fill pass follows reset.
//   Reset clears the valid bits, so no item in flight is delivered.
//   The receiver has no stall input and must take done items as they come.
// ----------------------------------------------------------------------------
module lch_to_srgb_convert_top (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	output logic          busy,
	input  lts_pkg::lch_t lch,
	output logic          done,
	output lts_pkg::rgb_t rgb
);
	import lts_pkg::*;

	logic vld_f;
	logic vld_l;
	logic vld_m;
	logic [2:0] vld_g;
	f_t   f_w   [3];
	lab_t lab_w [3];
	lin_t lin_w [3];
	logic [7:0] chan_w [3];

	assign busy = 1'b0;

	lts_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (start && !busy),
		.lch     (lch),
		.vld_out (vld_f),
		.f_out   (f_w)
	);

	lts_lab_inv u_lab (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_f),
		.f_in    (f_w),
		.vld_out (vld_l),
		.lab_out (lab_w)
	);

	lts_matrix u_mat (
		.clk     (clk),
		.arst_n  (arst_n),
		.vld_in  (vld_l),
		.lab_in  (lab_w),
		.vld_out (vld_m),
		.lin_out (lin_w)
	);

	for (genvar c = 0; c < 3; c++) begin : g_gam
		lts_gamma u_gam (
			.clk     (clk),
			.arst_n  (arst_n),
			.vld_in  (vld_m),
			.lin_in  (lin_w[c]),
			.vld_out (vld_g[c]),
			.chan    (chan_w[c])
		);
	end

	assign done      = vld_g[0];
	assign rgb.red   = chan_w[0];
	assign rgb.green = chan_w[1];
	assign rgb.blue  = chan_w[2];

	a_done_has_item: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, LATENCY))
		else $error("result strobe without an accepted item");

	a_item_gives_done: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |-> ##LATENCY done)
		else $error("accepted item produced no result");

	a_chan_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		(vld_g[1] == vld_g[0]) && (vld_g[2] == vld_g[0]))
		else $error("channel pipelines out of step");

endmodule

@@ rtl/lts_front.sv @@
// ----------------------------------------------------------------------------
// lts_front: hue lookup and Lab offsets
// Stages 1 to 7: hue wrap and table index, lightness scaling, cosine and
// sine lookup, chroma products and their scaled, rounded offsets.
// ----------------------------------------------------------------------------
module lts_front (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_in,
	input  lts_pkg::lch_t lch,
	output logic          vld_out,
	output lts_pkg::f_t   f_out [3]
);
	import lts_pkg::*;

	localparam logic [12:0] HUE_FULL  = 13'd5760;
	localparam logic [17:0] HUE_RECIP = 18'd186414;
	localparam int          HUE_SH    = 24;
	localparam logic [26:0] FY_RECIP  = 27'd74051161;
	localparam logic [25:0] RECIP125  = 26'd34359739;
	localparam logic [27:0] RECIP25   = 28'd171798692;

	localparam trig_tab_t COS_TAB = make_trig(1'b0);
	localparam trig_tab_t SIN_TAB = make_trig(1'b1);

	logic [6:0] vld_q;

	logic [12:0]           hue_w;
	logic [16:0]           hue_num_s1;
	logic [26:0]           fy_num_s1;
	logic [14:0]           chroma_s1;
	logic [34:0]           hue_prod;
	logic [53:0]           fy_prod;
	logic [TRIG_IDX_W-1:0] idx_s2;
	logic [FY_W-1:0]       fy_s2;
	logic [14:0]           chroma_s2;
	trig_t                 cos_s3;
	trig_t                 sin_s3;
	logic [FY_W-1:0]       fy_s3;
	logic [14:0]           chroma_s3;
	logic signed [33:0]    pc_s4;
	logic signed [33:0]    ps_s4;
	logic [FY_W-1:0]       fy_s4;
	logic signed [33:0]    abs_c;
	logic signed [33:0]    abs_s;
	logic [31:0]           sum_c;
	logic [31:0]           sum_s;
	logic [25:0]           a_s5;
	logic [24:0]           b_s5;
	logic                  neg_c_s5;
	logic                  neg_s_s5;
	logic [FY_W-1:0]       fy_s5;
	logic [51:0]           prod_a;
	logic [52:0]           prod_b;
	logic [18:0]           da_s6;
	logic [19:0]           db_s6;
	logic                  neg_c_s6;
	logic                  neg_s_s6;
	logic [FY_W-1:0]       fy_s6;
	f_t                    da_x;
	f_t                    db_x;
	f_t                    fy_x;
	f_t                    f_s7 [3];

	always_comb begin
		hue_w = (lch.hue >= HUE_FULL) ? lch.hue - HUE_FULL : lch.hue;
		hue_prod = 35'(hue_num_s1) * 35'(HUE_RECIP);
		fy_prod = 54'(fy_num_s1) * 54'(FY_RECIP);
		abs_c = pc_s4[33] ? -pc_s4 : pc_s4;
		abs_s = ps_s4[33] ? -ps_s4 : ps_s4;
		sum_c = abs_c[31:0] + 32'd4000;
		sum_s = abs_s[31:0] + 32'd1600;
		prod_a = 52'(a_s5) * 52'(RECIP125);
		prod_b = 53'(b_s5) * 53'(RECIP25);
		fy_x = F_W'(fy_s6);
		da_x = neg_c_s6 ? -F_W'(da_s6) : F_W'(da_s6);
		db_x = neg_s_s6 ? -F_W'(db_s6) : F_W'(db_s6);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[5:0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		hue_num_s1 <= {hue_w, 4'b0000} + 17'd45;
		fy_num_s1  <= {16'(lch.lightness) + 16'd4096, 11'd29};
		chroma_s1  <= lch.chroma;

		idx_s2    <= hue_prod[HUE_SH +: TRIG_IDX_W];
		fy_s2     <= fy_prod[32 +: FY_W];
		chroma_s2 <= chroma_s1;

		cos_s3    <= COS_TAB[idx_s2];
		sin_s3    <= SIN_TAB[idx_s2];
		fy_s3     <= fy_s2;
		chroma_s3 <= chroma_s2;

		pc_s4 <= 34'($signed({1'b0, chroma_s3})) * 34'(cos_s3);
		ps_s4 <= 34'($signed({1'b0, chroma_s3})) * 34'(sin_s3);
		fy_s4 <= fy_s3;

		a_s5     <= sum_c[31:6];
		b_s5     <= sum_s[31:7];
		neg_c_s5 <= pc_s4[33];
		neg_s_s5 <= ps_s4[33];
		fy_s5    <= fy_s4;

		da_s6    <= prod_a[50:32];
		db_s6    <= prod_b[51:32];
		neg_c_s6 <= neg_c_s5;
		neg_s_s6 <= neg_s_s5;
		fy_s6    <= fy_s5;

		f_s7[0] <= fy_x + da_x;
		f_s7[1] <= fy_x;
		f_s7[2] <= fy_x - db_x;
	end

	assign vld_out = vld_q[6];
	assign f_out   = f_s7;

endmodule

@@ rtl/lts_lab_inv.sv @@
// ----------------------------------------------------------------------------
// lts_lab_inv: inverse Lab companding
// Stages 8 and 9: cube above the knee, scaled linear segment below it, for
// the three offsets side by side.
// ----------------------------------------------------------------------------
module lts_lab_inv (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_in,
	input  lts_pkg::f_t   f_in [3],
	output logic          vld_out,
	output lts_pkg::lab_t lab_out [3]
);
	import lts_pkg::*;

	localparam f_t          LAB_KNEE  = F_W'(216946);
	localparam logic signed [22:0] LAB_OFFS = 23'sd144631;
	localparam logic [26:0] RECIP841  = 27'd81711626;

	logic [1:0] vld_q;

	logic signed [22:0] d      [3];
	logic signed [29:0] n      [3];
	logic signed [29:0] n_abs  [3];
	logic [41:0]        sq     [3];
	logic [42:0]        cube_p [3];
	logic [53:0]        lin_p  [3];
	logic [FY_W-1:0]    u_s8   [3];
	logic [21:0]        u2_s8  [3];
	logic [26:0]        mag_s8 [3];
	logic               neg_s8 [3];
	logic               knee_s8[3];
	lab_t               lin_x  [3];
	lab_t               lab_s9 [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			d[c] = 23'(f_in[c]) - LAB_OFFS;
			n[c] = 30'(d[c]) * 30'sd108;
			n_abs[c] = n[c][29] ? -n[c] : n[c];
			sq[c] = 42'(f_in[c][FY_W-1:0]) * 42'(f_in[c][FY_W-1:0]) + 42'(1 << 19);
			cube_p[c] = 43'(u2_s8[c]) * 43'(u_s8[c]) + 43'(1 << 19);
			lin_p[c] = 54'(mag_s8[c]) * 54'(RECIP841);
			lin_x[c] = neg_s8[c] ? -LAB_W'(lin_p[c][52:36]) : LAB_W'(lin_p[c][52:36]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			knee_s8[c] <= f_in[c] > LAB_KNEE;
			u_s8[c]    <= f_in[c][FY_W-1:0];
			u2_s8[c]   <= sq[c][41:20];
			mag_s8[c]  <= n_abs[c][26:0] + 27'd420;
			neg_s8[c]  <= n[c][29];
			lab_s9[c]  <= knee_s8[c] ? LAB_W'(cube_p[c][42:20]) : lin_x[c];
		end
	end

	assign vld_out = vld_q[1];
	assign lab_out = lab_s9;

endmodule

@@ rtl/lts_matrix.sv @@
// ----------------------------------------------------------------------------
// lts_matrix: Lab to linear RGB
// Stages 10 to 12: nine coefficient products, row sums, and the rounded
// scale back to Q20.
// ----------------------------------------------------------------------------
module lts_matrix (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_in,
	input  lts_pkg::lab_t lab_in [3],
	output logic          vld_out,
	output lts_pkg::lin_t lin_out [3]
);
	import lts_pkg::*;

	logic [2:0] vld_q;

	logic signed [PROD_W-1:0] prod_s10 [3][3];
	logic signed [ACC_W-1:0]  acc_s11  [3];
	logic signed [ACC_W-1:0]  acc_abs  [3];
	logic [ACC_W-1:0]         acc_rnd  [3];
	lin_t                     lin_x    [3];
	lin_t                     lin_s12  [3];

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			acc_abs[c] = acc_s11[c][ACC_W-1] ? -acc_s11[c] : acc_s11[c];
			acc_rnd[c] = acc_abs[c] + ACC_W'(1 << 23);
			lin_x[c] = acc_s11[c][ACC_W-1] ? -LIN_W'(acc_rnd[c][ACC_W-1:24])
			                                : LIN_W'(acc_rnd[c][ACC_W-1:24]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[1:0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		for (int c = 0; c < 3; c++) begin
			for (int i = 0; i < 3; i++) begin
				prod_s10[c][i] <= PROD_W'(MAT[c][i]) * PROD_W'(lab_in[i]);
			end
			acc_s11[c] <= ACC_W'(prod_s10[c][0]) + ACC_W'(prod_s10[c][1])
			            + ACC_W'(prod_s10[c][2]);
			lin_s12[c] <= lin_x[c];
		end
	end

	assign vld_out = vld_q[2];
	assign lin_out = lin_s12;

endmodule

@@ rtl/lts_gamma.sv @@
// ----------------------------------------------------------------------------
// lts_gamma: sRGB gamma for one channel
// Stages 13 to 16: range split, interpolated power table, offset and scale
// to 0..255 with rounding and saturation.
// ----------------------------------------------------------------------------
module lts_gamma (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          vld_in,
	input  lts_pkg::lin_t lin_in,
	output logic          vld_out,
	output logic [7:0]    chan
);
	import lts_pkg::*;

	localparam int FRAC_W = 20 - GAM_IDX_W;
	localparam pow_tab_t POW_TAB = make_pow();
	localparam lin_t     LIN_ONE  = LIN_W'(1 << 20);
	localparam lin_t     GAM_KNEE = LIN_W'(3282);
	localparam logic [38:0] CURVE_FLOOR = 39'(561) << 24;
	localparam logic [14:0] CURVE_OFFS  = 15'd541;

	typedef enum logic [1:0] {
		GM_ZERO  = 2'd0,
		GM_FULL  = 2'd1,
		GM_KNEE  = 2'd2,
		GM_CURVE = 2'd3
	} gam_mode_t;

	logic [3:0] vld_q;

	gam_mode_t              mode_x;
	logic [GAM_IDX_W-1:0]   idx;
	logic [26:0]            kp;
	logic [POW_W-1:0]       diff;
	logic [POW_W+FRAC_W-1:0] ip;
	logic [18:0]            krp;
	logic [14:0]            q;
	logic [23:0]            rp;
	logic [9:0]             r;
	logic [7:0]             chan_x;

	gam_mode_t        mode_s13;
	logic [POW_W-1:0] t0_s13;
	logic [POW_W-1:0] t1_s13;
	logic [FRAC_W-1:0] frac_s13;
	logic [6:0]       kq_s13;
	gam_mode_t        mode_s14;
	logic [POW_W-1:0] g_s14;
	logic [7:0]       kr_s14;
	gam_mode_t        mode_s15;
	logic [38:0]      num_s15;
	logic [7:0]       kr_s15;
	logic [7:0]       chan_s16;

	always_comb begin
		if (lin_in <= lin_t'(0)) mode_x = GM_ZERO;
		else if (lin_in >= LIN_ONE) mode_x = GM_FULL;
		else if (lin_in <= GAM_KNEE) mode_x = GM_KNEE;
		else mode_x = GM_CURVE;
		idx = lin_in[19 -: GAM_IDX_W];
		kp = 27'(lin_in[11:0]) * 27'd16473 + 27'd2621440;
		diff = t1_s13 - t0_s13;
		ip = (POW_W + FRAC_W)'(diff) * (POW_W + FRAC_W)'(frac_s13);
		krp = 19'(kq_s13) * 19'd3277;
		q = num_s15[38:24] - CURVE_OFFS;
		rp = 24'(q[14:3]) * 24'd3277;
		r = rp[23:14];
		case (mode_s15)
			GM_ZERO:  chan_x = 8'd0;
			GM_FULL:  chan_x = 8'd255;
			GM_KNEE:  chan_x = kr_s15;
			GM_CURVE: begin
				if (num_s15 <= CURVE_FLOOR) chan_x = 8'd0;
				else if (r > 10'd255) chan_x = 8'd255;
				else chan_x = r[7:0];
			end
			default:  chan_x = 8'd0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= {vld_q[2:0], vld_in};
		end
	end

	always_ff @(posedge clk) begin
		mode_s13 <= mode_x;
		t0_s13   <= POW_TAB[POW_IDX_W'(idx)];
		t1_s13   <= POW_TAB[POW_IDX_W'(idx) + POW_IDX_W'(1)];
		frac_s13 <= lin_in[FRAC_W-1:0];
		kq_s13   <= kp[26:20];

		mode_s14 <= mode_s13;
		g_s14    <= t0_s13 + ip[FRAC_W +: POW_W];
		kr_s14   <= 8'(krp[18:14]);

		mode_s15 <= mode_s14;
		num_s15  <= 39'(g_s14) * 39'd10761;
		kr_s15   <= kr_s14;

		chan_s16 <= chan_x;
	end

	assign vld_out = vld_q[3];
	assign chan    = chan_s16;

endmodule
